/* design/nrbh_pkg.sv */
package nrbh_pkg;

    // Q16.8 fixed point
    localparam int FRAC = 8;
    localparam int RW = 24;            // register and result width
    localparam int CW = 25;            // rectangle corner width after scaling
    localparam int DW = 27;            // coordinate difference / multiplier operand
    localparam int PW = 2 * DW;        // product width
    localparam int AW = PW + 2;        // cross-product accumulator width
    localparam int SQ_W = 50;          // sum of squares width
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int CNT_W = 6;

    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RAY_START_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_START_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_END_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_END_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 3'd4;

    localparam logic [RW-1:0] MAX_DISTANCE_RESET = 24'd2560000;

    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_TARGET = 2'd2;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_LEFT   = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] b;
        logic                 active;
        logic                 target;
        logic                 last;
    } rect_item_t;

    typedef struct packed {
        logic signed [RW-1:0] start_x;
        logic signed [RW-1:0] start_y;
        logic signed [RW-1:0] end_x;
        logic signed [RW-1:0] end_y;
        logic [RW-1:0]        max_distance;
    } ray_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_FIX,
        ST_SQX,
        ST_SQY,
        ST_SQSUM,
        ST_SQRT,
        ST_UPD,
        ST_NEXT,
        ST_DONE,
        ST_EMIT
    } back_state_t;

endpackage

/* design/nrbh_front.sv */
module nrbh_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nrbh_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    output logic                               q_valid,
    input  logic                               q_ready,
    output nrbh_pkg::rect_item_t               q_item
);
    import nrbh_pkg::*;

    logic signed [15:0]   rect_left;
    logic signed [15:0]   rect_top;
    logic [11:0]          rect_width;
    logic [11:0]          rect_height;
    logic signed [CW-1:0] l_fx;
    logic signed [CW-1:0] t_fx;
    logic                 active;
    logic                 target;

    assign rect_left   = s_tdata[15:0];
    assign rect_top    = s_tdata[31:16];
    assign rect_width  = s_tdata[43:32];
    assign rect_height = s_tdata[55:44];

    assign l_fx = CW'(rect_left) <<< FRAC;
    assign t_fx = CW'(rect_top) <<< FRAC;

    always_comb
    begin
        unique case (s_tuser)
            KIND_WALL:
            begin
                active = 1'b1;
                target = 1'b0;
            end
            KIND_TARGET:
            begin
                active = 1'b1;
                target = 1'b1;
            end
            default:
            begin
                active = 1'b0;
                target = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        q_item.l      = l_fx;
        q_item.t      = t_fx;
        q_item.r      = l_fx + signed'(CW'(rect_width) << FRAC);
        q_item.b      = t_fx + signed'(CW'(rect_height) << FRAC);
        q_item.active = active;
        q_item.target = target;
        q_item.last   = s_tlast;
    end

    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;

endmodule

/* design/nrbh_queue.sv */
module nrbh_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nrbh_pkg::rect_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nrbh_pkg::rect_item_t out_item
);
    import nrbh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rect_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != (PTR_W + 1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

/* design/nrbh_back.sv */
module nrbh_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nrbh_pkg::ray_cfg_t                 cfg,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  nrbh_pkg::rect_item_t               q_item,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nrbh_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                         m_tuser
);
    import nrbh_pkg::*;

    // product steps of the edge test
    localparam logic [2:0] P_DEN_A = 3'd0;
    localparam logic [2:0] P_DEN_B = 3'd1;
    localparam logic [2:0] P_N1_A  = 3'd2;
    localparam logic [2:0] P_N1_B  = 3'd3;
    localparam logic [2:0] P_N2_A  = 3'd4;
    localparam logic [2:0] P_N2_B  = 3'd5;
    localparam logic [2:0] P_NUM   = 3'd6;

    localparam logic signed [AW-1:0] LIM = AW'(1) <<< RW;

    back_state_t          state_reg, state_next;
    rect_item_t           item_reg;
    logic [1:0]           edge_reg;
    logic [2:0]           idx_reg;
    logic signed [AW-1:0] den_reg, n1_reg, n2_reg;
    logic signed [PW-1:0] num_reg, prod_reg;
    logic [PW-1:0]        quo_reg;
    logic [DW-1:0]        rem_reg, dvs_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [DW-1:0] ox_reg, oy_reg;
    logic [SQ_W-1:0]      sq_reg, root_reg;
    logic [RW-1:0]        best_dist_reg;
    logic signed [RW-1:0] best_x_reg, best_y_reg;
    logic                 found_reg, best_tgt_reg, run_open_reg, out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [1:0]           out_user_reg;

    logic signed [DW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [DW-1:0] dx12, dy12, dx34, dy34, dx13, dy13;
    logic signed [DW-1:0] mul_a, mul_b, dd, dd_abs, exact;
    logic signed [AW-1:0] den_abs, n1_adj, n2_adj, fo, ex_ext, ox_full, oy_full;
    logic signed [PW-1:0] num_abs;
    logic                 horiz, edge_hit, in_lim;
    logic [DW-1:0]        rem_sh, rem_nx;
    logic                 rem_ge;
    logic [CNT_W-1:0]     sh;
    logic [SQ_W-1:0]      bitv, trial;
    logic                 take;
    logic [RW:0]          root_dist;
    logic                 closer;
    logic signed [DW-1:0] sum_x, sum_y;
    logic                 out_load;

    function automatic logic signed [RW-1:0] sat24(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        hi = (DW'(1) <<< (RW - 1)) - 1;
        lo = -(DW'(1) <<< (RW - 1));
        if (v > hi)
            return RW'(hi);
        else if (v < lo)
            return RW'(lo);
        return RW'(v);
    endfunction

    assign x1 = DW'(cfg.start_x);
    assign y1 = DW'(cfg.start_y);
    assign x2 = DW'(cfg.end_x);
    assign y2 = DW'(cfg.end_y);

    always_comb
    begin
        unique case (edge_reg)
            EDGE_TOP:
            begin
                x3 = DW'(item_reg.l); y3 = DW'(item_reg.t);
                x4 = DW'(item_reg.r); y4 = DW'(item_reg.t);
            end
            EDGE_LEFT:
            begin
                x3 = DW'(item_reg.l); y3 = DW'(item_reg.t);
                x4 = DW'(item_reg.l); y4 = DW'(item_reg.b);
            end
            EDGE_RIGHT:
            begin
                x3 = DW'(item_reg.r); y3 = DW'(item_reg.t);
                x4 = DW'(item_reg.r); y4 = DW'(item_reg.b);
            end
            default:
            begin
                x3 = DW'(item_reg.l); y3 = DW'(item_reg.b);
                x4 = DW'(item_reg.r); y4 = DW'(item_reg.b);
            end
        endcase
    end

    assign dx12  = x1 - x2;
    assign dy12  = y1 - y2;
    assign dx34  = x3 - x4;
    assign dy34  = y3 - y4;
    assign dx13  = x1 - x3;
    assign dy13  = y1 - y3;
    assign horiz = (y3 == y4);

    // one shared multiplier for the cross products and the squares
    always_comb
    begin
        mul_a = dx12;
        mul_b = dy34;
        if (state_reg == ST_SQX)
        begin
            mul_a = ox_reg;
            mul_b = ox_reg;
        end
        else if (state_reg == ST_SQY)
        begin
            mul_a = oy_reg;
            mul_b = oy_reg;
        end
        else
        begin
            unique case (idx_reg)
                P_DEN_A: begin mul_a = dx12; mul_b = dy34; end
                P_DEN_B: begin mul_a = dy12; mul_b = dx34; end
                P_N1_A:  begin mul_a = dx13; mul_b = dy34; end
                P_N1_B:  begin mul_a = dy13; mul_b = dx34; end
                P_N2_A:  begin mul_a = dx12; mul_b = dy13; end
                P_N2_B:  begin mul_a = dy12; mul_b = dx13; end
                P_NUM:
                begin
                    mul_a = horiz ? dy13 : dx13;
                    mul_b = horiz ? dx12 : dy12;
                end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // sign normalised so that den > 0
    assign den_abs = den_reg[AW-1] ? -den_reg : den_reg;
    assign n1_adj  = den_reg[AW-1] ? -n1_reg : n1_reg;
    assign n2_adj  = den_reg[AW-1] ? -n2_reg : n2_reg;
    assign dd      = horiz ? -dy12 : -dx12;
    assign dd_abs  = dd[DW-1] ? -dd : dd;
    assign num_abs = num_reg[PW-1] ? -num_reg : num_reg;
    assign edge_hit = (den_reg != '0) && (n1_adj > 0) && (n2_adj > 0)
                      && (n2_adj < den_abs) && (dd != '0);

    // restoring divider, one quotient bit a cycle
    assign rem_sh = {rem_reg[DW-2:0], quo_reg[PW-1]};
    assign rem_ge = rem_sh >= dvs_reg;
    assign rem_nx = rem_ge ? rem_sh - dvs_reg : rem_sh;

    // floor of the signed quotient
    assign fo = neg_reg ? -signed'(AW'(quo_reg)) - AW'(rem_reg != '0)
                        : signed'(AW'(quo_reg));
    assign exact   = horiz ? -dy13 : -dx13;
    assign ex_ext  = AW'(exact);
    assign ox_full = horiz ? fo : ex_ext;
    assign oy_full = horiz ? ex_ext : fo;
    assign in_lim  = (ox_full < LIM) && (ox_full > -LIM) && (oy_full < LIM) && (oy_full > -LIM);

    // square root, two bits of the radicand a cycle
    assign sh    = CNT_W'(SQ_W - 2) - {cnt_reg[CNT_W-2:0], 1'b0};
    assign bitv  = SQ_W'(1) << sh;
    assign trial = root_reg + bitv;
    assign take  = sq_reg >= trial;

    assign root_dist = root_reg[RW:0];
    assign closer    = root_dist < {1'b0, best_dist_reg};
    assign sum_x     = x1 + ox_reg;
    assign sum_y     = y1 + oy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = q_item.active ? ST_MUL : ST_DONE;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
                state_next = (idx_reg == P_NUM) ? ST_CHECK : ST_MUL;
            ST_CHECK:
                state_next = edge_hit ? ST_DIV : ST_NEXT;
            ST_DIV:
                if (cnt_reg == CNT_W'(PW - 1))
                    state_next = ST_FIX;
            ST_FIX:
                state_next = in_lim ? ST_SQX : ST_NEXT;
            ST_SQX:
                state_next = ST_SQY;
            ST_SQY:
                state_next = ST_SQSUM;
            ST_SQSUM:
                state_next = ST_SQRT;
            ST_SQRT:
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = ST_UPD;
            ST_UPD:
                state_next = ST_NEXT;
            ST_NEXT:
                state_next = (edge_reg == EDGE_BOTTOM) ? ST_DONE : ST_MUL;
            ST_DONE:
                state_next = item_reg.last ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_ready  = 1'b1;
            ST_EMIT: out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_open_reg  <= 1'b0;
            found_reg     <= 1'b0;
            best_tgt_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_ready && q_valid)
            begin
                run_open_reg <= 1'b1;
                if (!run_open_reg)
                begin
                    found_reg    <= 1'b0;
                    best_tgt_reg <= 1'b0;
                end
            end
            if (state_reg == ST_UPD && closer)
            begin
                found_reg    <= 1'b1;
                best_tgt_reg <= item_reg.target;
            end
            if (out_load)
            begin
                run_open_reg  <= 1'b0;
                found_reg     <= 1'b0;
                best_tgt_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    item_reg <= q_item;
                    edge_reg <= EDGE_TOP;
                    idx_reg  <= P_DEN_A;
                    if (!run_open_reg)
                    begin
                        best_dist_reg <= cfg.max_distance;
                        best_x_reg    <= cfg.end_x;
                        best_y_reg    <= cfg.end_y;
                    end
                end
            ST_MUL:
                prod_reg <= mul_a * mul_b;
            ST_ACC:
            begin
                case (idx_reg)
                    P_DEN_A: den_reg <= AW'(prod_reg);
                    P_DEN_B: den_reg <= den_reg - AW'(prod_reg);
                    P_N1_A:  n1_reg  <= AW'(prod_reg);
                    P_N1_B:  n1_reg  <= n1_reg - AW'(prod_reg);
                    P_N2_A:  n2_reg  <= -AW'(prod_reg);
                    P_N2_B:  n2_reg  <= n2_reg + AW'(prod_reg);
                    default: num_reg <= prod_reg;
                endcase
                idx_reg <= idx_reg + 1'b1;
            end
            ST_CHECK:
            begin
                rem_reg <= '0;
                quo_reg <= num_abs;
                dvs_reg <= dd_abs;
                neg_reg <= num_reg[PW-1] ^ dd[DW-1];
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_nx;
                quo_reg <= {quo_reg[PW-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_FIX:
            begin
                ox_reg <= DW'(ox_full);
                oy_reg <= DW'(oy_full);
            end
            ST_SQX:
                prod_reg <= mul_a * mul_b;
            ST_SQY:
            begin
                sq_reg   <= SQ_W'(prod_reg);
                prod_reg <= mul_a * mul_b;
            end
            ST_SQSUM:
            begin
                sq_reg   <= sq_reg + SQ_W'(prod_reg);
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                if (take)
                begin
                    sq_reg   <= sq_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                    root_reg <= root_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_UPD:
                if (closer)
                begin
                    best_dist_reg <= root_dist[RW-1:0];
                    best_x_reg    <= sat24(sum_x);
                    best_y_reg    <= sat24(sum_y);
                end
            ST_NEXT:
            begin
                edge_reg <= edge_reg + 1'b1;
                idx_reg  <= P_DEN_A;
            end
            ST_EMIT:
                if (out_load)
                begin
                    out_data_reg <= {best_dist_reg, best_y_reg, best_x_reg};
                    out_user_reg <= {found_reg && best_tgt_reg, found_reg};
                end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dvs_reg != '0)
        else $error("divider running with zero divisor");

    a_tgt_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> !best_tgt_reg)
        else $error("target flag set without a hit");

    a_emit_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && !run_open_reg)
        else $error("result load did not close the run");

    a_best_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && closer) |=> best_dist_reg < $past(best_dist_reg))
        else $error("kept distance did not shrink on update");
`endif

endmodule

/* design/nearest_ray_box_hit.sv */
// channel | dir | handshake              | payload
// s_*     | in  | s_tvalid / s_tready    | tdata: rect_left, rect_top, rect_width, rect_height;
//         |     |                        | tuser: rect_kind; tlast: last_rect
// m_*     | out | m_tvalid / m_tready    | tdata: hit_x, hit_y, hit_distance;
//         |     |                        | tuser: any_hit, hit_target
// cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// An ignored rectangle passes only through the done state in the back end; a wall or target
// runs every edge; an edge that hits runs the restoring divider and, if the hit is in range,
// the square root, all on one shared 27x27 multiplier. The last item also passes the emit
// state. Reset clears control state only; no clearing pass. The input queue decouples s_tready
// from the back end; the output register holds a result while the next run is processed.
module nearest_ray_box_hit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] rect_left, [31:16] rect_top, [43:32] rect_width, [55:44] rect_height
    input  logic [nrbh_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [1:0] rect_kind
    input  logic [1:0]                           s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [23:0] hit_x, [47:24] hit_y, [71:48] hit_distance
    output logic [nrbh_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [0] any_hit, [1] hit_target
    output logic [1:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nrbh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nrbh_pkg::RW-1:0]              cfg_data
);
    import nrbh_pkg::*;

    ray_cfg_t   cfg_reg;
    rect_item_t f_item, b_item;
    logic       f_valid, f_ready, b_valid, b_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x      <= '0;
            cfg_reg.start_y      <= '0;
            cfg_reg.end_x        <= '0;
            cfg_reg.end_y        <= '0;
            cfg_reg.max_distance <= MAX_DISTANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RAY_START_X:  cfg_reg.start_x      <= cfg_data;
                CFG_RAY_START_Y:  cfg_reg.start_y      <= cfg_data;
                CFG_RAY_END_X:    cfg_reg.end_x        <= cfg_data;
                CFG_RAY_END_Y:    cfg_reg.end_y        <= cfg_data;
                CFG_MAX_DISTANCE: cfg_reg.max_distance <= cfg_data;
                default: ;
            endcase
        end
    end

    nrbh_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    nrbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    nrbh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_item   (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
